// ===== design/mvpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvpd_pkg - shared constants for the motor velocity PD controller
// Field widths, item kind codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package mvpd_pkg;

	// Fraction bits of the filtered velocity (Q16.16)
	localparam int FRAC_BITS = 16;

	// Field widths
	localparam int KIND_W     = 2;
	localparam int DIR_W      = 2;
	localparam int DES_W      = 16;
	localparam int CMD_W      = 11;
	localparam int LIMIT_W    = 10;
	localparam int DUTY_W     = 16;
	localparam int TICK_W     = 16;
	localparam int VEL_W      = 32;
	localparam int ALPHA_W    = 16;
	localparam int SCALE_W    = 24;
	localparam int GAIN_W     = 16;
	localparam int PWM_W      = 16;
	localparam int DIVIDEND_W = DUTY_W + LIMIT_W;
	localparam int DIV_CNT_W  = $clog2(DUTY_W + 1);

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;

	// Item kinds
	localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CTRL   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_LOOP_MODE = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ALPHA     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_SCALE     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_KP        = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_KD        = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_LIMIT     = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] REG_PWM_TOP   = 3'd6;

	// Loop modes
	localparam logic MODE_CLOSED = 1'b0;
	localparam logic MODE_OPEN   = 1'b1;

	// Register reset values
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd32768;
	localparam logic [SCALE_W-1:0] SCALE_RST = 24'd65536;
	localparam logic [GAIN_W-1:0]  KP_RST    = 16'd154;
	localparam logic [GAIN_W-1:0]  KD_RST    = 16'd1024;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 10'd1000;
	localparam logic [PWM_W-1:0]   PWM_RST   = 16'd1023;

endpackage
`default_nettype wire

// ===== design/mvpd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mvpd_div - iterative duty divider
// Restoring division, one quotient bit a cycle. The dividend's upper part
// must be below the divisor so that the quotient fits DUTY_W bits.
// ----------------------------------------------------------------------------
module mvpd_div
	import mvpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DIVIDEND_W-1:0] dividend,
	input  wire logic [LIMIT_W-1:0]    divisor,
	output logic                       done,
	output logic [DUTY_W-1:0]          quotient
);

	logic [LIMIT_W-1:0]   rem_q;
	logic [DUTY_W-1:0]    sh_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [LIMIT_W:0]     trial;
	logic                 fits;
	logic [LIMIT_W:0]     diff;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, sh_q[DUTY_W-1]};
		fits  = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	// Control: count the quotient bits, pulse done after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DUTY_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DIVIDEND_W-1:DUTY_W];
			sh_q  <= dividend[DUTY_W-1:0];
		end else if (busy_q) begin
			rem_q <= fits ? diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
			sh_q  <= {sh_q[DUTY_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

	// A division is never restarted while running
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	// Done follows the last step of a running division
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a running division");

endmodule
`default_nettype wire

// ===== design/motor_velocity_pd_controller_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_velocity_pd_controller_top - encoder counting, velocity filter and
// PD speed loop, with an open loop mode
// One shared 34x26 multiplier under a sequencer; the PWM duty comes
// from a bit-serial divider.
//
//   Port group   Dir   Contents
//   s_*          in    items: tuser kind, tdata encoder levels, step, target
//   m_*          out   results: direction, duty, command
//   cfg_*        in    register writes, index 0 to 6
//
// Each item runs the steps of its kind (none for an unused kind) and then
// the duty step, a 16-step division that a zero limit skips.
// s_tready is high only while the sequencer is idle. A finished result waits
// in the output register while the next item is accepted and worked on; if
// that register is still full when the next item finishes, the sequencer
// holds and the input stays stalled.
// Reset clears the sequencer, controller state and output valid; registers return to defaults.
// ----------------------------------------------------------------------------
module motor_velocity_pd_controller_top
	import mvpd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [23:0]           s_tdata,  // enc_a, enc_b, edge_dir[1:0], desired_velocity[15:0]
	input  wire logic [KIND_W-1:0]     s_tuser,  // kind[1:0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [31:0]                m_tdata,  // direction, duty[15:0], command_out[10:0]
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Shared multiplier operand and product widths
	localparam int MA_W = 34;
	localparam int MB_W = 26;
	localparam int PW   = MA_W + MB_W;

	localparam logic signed [PW-1:0] I32_MAX = PW'(32'h7FFF_FFFF);
	localparam logic signed [PW-1:0] I32_MIN = ~I32_MAX;

	// Sequencer states
	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] ST_IDLE = 5'd0;
	localparam logic [ST_W-1:0] ST_EDGE = 5'd1;
	localparam logic [ST_W-1:0] ST_V1   = 5'd2;
	localparam logic [ST_W-1:0] ST_V2   = 5'd3;
	localparam logic [ST_W-1:0] ST_V3   = 5'd4;
	localparam logic [ST_W-1:0] ST_V4   = 5'd5;
	localparam logic [ST_W-1:0] ST_C1   = 5'd6;
	localparam logic [ST_W-1:0] ST_C2   = 5'd7;
	localparam logic [ST_W-1:0] ST_C3   = 5'd8;
	localparam logic [ST_W-1:0] ST_C4   = 5'd9;
	localparam logic [ST_W-1:0] ST_C5   = 5'd10;
	localparam logic [ST_W-1:0] ST_C6   = 5'd11;
	localparam logic [ST_W-1:0] ST_C7   = 5'd12;
	localparam logic [ST_W-1:0] ST_C8   = 5'd13;
	localparam logic [ST_W-1:0] ST_C9   = 5'd14;
	localparam logic [ST_W-1:0] ST_C10  = 5'd15;
	localparam logic [ST_W-1:0] ST_O1   = 5'd16;
	localparam logic [ST_W-1:0] ST_O2   = 5'd17;
	localparam logic [ST_W-1:0] ST_D1   = 5'd18;
	localparam logic [ST_W-1:0] ST_D2   = 5'd19;
	localparam logic [ST_W-1:0] ST_DW   = 5'd20;
	localparam logic [ST_W-1:0] ST_DONE = 5'd21;

	// Divide by 2^n, rounding toward zero
	function automatic logic signed [PW-1:0] trunc_shr(input logic signed [PW-1:0] x,
			input int unsigned n);
		logic signed [PW-1:0] bias;
		bias = x[PW-1] ? ((PW'(1) << n) - PW'(1)) : '0;
		return (x + bias) >>> n;
	endfunction

	// Saturate to signed 32 bits
	function automatic logic signed [VEL_W-1:0] sat32(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] y;
		y = (x > I32_MAX) ? I32_MAX : ((x < I32_MIN) ? I32_MIN : x);
		return y[VEL_W-1:0];
	endfunction

	// Clamp to plus or minus the command limit
	function automatic logic signed [CMD_W-1:0] clamp_cmd(input logic signed [PW-1:0] x,
			input logic [LIMIT_W-1:0] lim);
		logic signed [PW-1:0] lim_s;
		logic signed [PW-1:0] y;
		lim_s = PW'(lim);
		y = (x > lim_s) ? lim_s : ((x < -lim_s) ? -lim_s : x);
		return y[CMD_W-1:0];
	endfunction

	// Configuration registers
	logic               mode_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [SCALE_W-1:0] scale_q;
	logic [GAIN_W-1:0]  kp_q;
	logic [GAIN_W-1:0]  kd_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [PWM_W-1:0]   pwm_top_q;

	// Controller state
	logic signed [TICK_W-1:0] tick_q;
	logic signed [VEL_W-1:0]  vel_q;
	logic signed [CMD_W-1:0]  cmd_q;
	logic signed [VEL_W-1:0]  perr_q;

	// Working registers
	logic [ST_W-1:0]          state_q;
	logic                     enc_a_q;
	logic                     enc_b_q;
	logic signed [DIR_W-1:0]  dir_q;
	logic signed [DES_W-1:0]  des_q;
	logic signed [PW-1:0]     p_q;
	logic signed [PW-1:0]     acc_q;
	logic signed [PW-1:0]     t_q;
	logic signed [PW-1:0]     sum_q;
	logic signed [VEL_W-1:0]  err_q;
	logic [DUTY_W-1:0]        duty_q;

	// Output register
	logic                     m_valid_q;
	logic                     out_dir_q;
	logic [DUTY_W-1:0]        out_duty_q;
	logic [CMD_W-1:0]         out_cmd_q;

	logic signed [MA_W-1:0]   mul_a;
	logic signed [MB_W-1:0]   mul_b;
	logic [CMD_W-1:0]         cmd_abs;
	logic [LIMIT_W-1:0]       mag;
	logic                     in_acc;
	logic                     out_load;
	logic                     div_start;
	logic                     div_done;
	logic [DUTY_W-1:0]        div_quot;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, out_cmd_q, out_duty_q, out_dir_q};

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_CLOSED;
			alpha_q   <= ALPHA_RST;
			scale_q   <= SCALE_RST;
			kp_q      <= KP_RST;
			kd_q      <= KD_RST;
			limit_q   <= LIMIT_RST;
			pwm_top_q <= PWM_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_LOOP_MODE: mode_q    <= cfg_wdata[0];
				REG_ALPHA:     alpha_q   <= cfg_wdata[ALPHA_W-1:0];
				REG_SCALE:     scale_q   <= cfg_wdata[SCALE_W-1:0];
				REG_KP:        kp_q      <= cfg_wdata[GAIN_W-1:0];
				REG_KD:        kd_q      <= cfg_wdata[GAIN_W-1:0];
				REG_LIMIT:     limit_q   <= cfg_wdata[LIMIT_W-1:0];
				REG_PWM_TOP:   pwm_top_q <= cfg_wdata[PWM_W-1:0];
				default: ;
			endcase
		end
	end

	// Command magnitude, held to the limit
	always_comb begin
		cmd_abs = cmd_q[CMD_W-1] ? CMD_W'(-cmd_q) : CMD_W'(cmd_q);
		mag     = (cmd_abs > {1'b0, limit_q}) ? limit_q : cmd_abs[LIMIT_W-1:0];
	end

	// Select the shared multiplier's operands for this step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_V1: begin
				mul_a = MA_W'(vel_q);
				mul_b = MB_W'(17'h1_0000 - {1'b0, alpha_q});
			end
			ST_V2: begin
				mul_a = MA_W'(tick_q);
				mul_b = MB_W'(alpha_q);
			end
			ST_C1: begin
				mul_a = MA_W'(vel_q);
				mul_b = MB_W'(scale_q);
			end
			ST_C4: begin
				mul_a = acc_q[MA_W-1:0];
				mul_b = MB_W'(limit_q);
			end
			ST_C6: begin
				mul_a = MA_W'(err_q);
				mul_b = MB_W'(kp_q);
			end
			ST_C7: begin
				mul_a = acc_q[MA_W-1:0];
				mul_b = MB_W'(kd_q);
			end
			ST_O1: begin
				mul_a = MA_W'(des_q);
				mul_b = MB_W'(limit_q);
			end
			ST_D1: begin
				mul_a = MA_W'(mag);
				mul_b = MB_W'(pwm_top_q);
			end
			default: ;
		endcase
	end

	// Product register of the shared multiplier
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	assign div_start = (state_q == ST_D2);

	mvpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (p_q[DIVIDEND_W-1:0]),
		.divisor  (limit_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Output valid: raise on a finished item, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Sequencer and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tick_q    <= '0;
			vel_q     <= '0;
			cmd_q     <= '0;
			perr_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (s_tuser)
							KIND_EDGE:   state_q <= ST_EDGE;
							KIND_SAMPLE: state_q <= ST_V1;
							KIND_CTRL:   state_q <= (mode_q == MODE_OPEN) ? ST_O1 : ST_C1;
							KIND_NONE:   state_q <= ST_D1;
						endcase
					end
				end
				// Count the encoder edge
				ST_EDGE: begin
					tick_q  <= (enc_a_q != enc_b_q) ? tick_q + TICK_W'(dir_q)
						: tick_q - TICK_W'(dir_q);
					state_q <= ST_D1;
				end
				// Low-pass filter: (1 - alpha) * v + alpha * count
				ST_V1: state_q <= ST_V2;
				ST_V2: state_q <= ST_V3;
				ST_V3: state_q <= ST_V4;
				ST_V4: begin
					vel_q   <= sat32(trunc_shr(acc_q, 16));
					tick_q  <= '0;
					state_q <= ST_D1;
				end
				// PD update
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_C3;
				ST_C3: state_q <= ST_C4;
				ST_C4: state_q <= ST_C5;
				ST_C5: state_q <= ST_C6;
				ST_C6: state_q <= ST_C7;
				ST_C7: state_q <= ST_C8;
				ST_C8: state_q <= ST_C9;
				ST_C9: state_q <= ST_C10;
				ST_C10: begin
					cmd_q   <= clamp_cmd(trunc_shr(sum_q, 16), limit_q);
					perr_q  <= err_q;
					state_q <= ST_D1;
				end
				// Open loop: desired times limit
				ST_O1: state_q <= ST_O2;
				ST_O2: begin
					cmd_q   <= clamp_cmd(trunc_shr(p_q, 14), limit_q);
					state_q <= ST_D1;
				end
				// Duty: pwm_top * magnitude / limit
				ST_D1: state_q <= (limit_q == '0) ? ST_DONE : ST_D2;
				ST_D2: state_q <= ST_DW;
				ST_DW: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				// Hand the result to the output register once it is free
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload and intermediate registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			enc_a_q <= s_tdata[0];
			enc_b_q <= s_tdata[1];
			dir_q   <= s_tdata[3:2];
			des_q   <= s_tdata[19:4];
		end
		case (state_q)
			ST_V2:  acc_q <= p_q;
			ST_V3:  acc_q <= acc_q + (p_q <<< FRAC_BITS);
			ST_C2:  acc_q <= trunc_shr(p_q, FRAC_BITS + 8);
			ST_C3:  acc_q <= acc_q - (PW'(des_q) <<< 2);
			ST_C5:  err_q <= sat32(p_q);
			ST_C6:  acc_q <= PW'(err_q) - PW'(perr_q);
			ST_C7:  t_q   <= trunc_shr(p_q, 8);
			ST_C8: begin
				sum_q <= t_q + (PW'(cmd_q) <<< 16);
				t_q   <= trunc_shr(p_q, 8);
			end
			ST_C9:  sum_q <= sum_q + t_q;
			ST_D1:  duty_q <= '0;
			ST_DW: begin
				if (div_done) begin
					duty_q <= div_quot;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_dir_q  <= !cmd_q[CMD_W-1];
			out_duty_q <= duty_q;
			out_cmd_q  <= cmd_q;
		end
	end

	// A control step leaves the command within the limit it was computed with
	a_cmd_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_C10 || state_q == ST_O2) |=>
			(cmd_q <= $signed({1'b0, $past(limit_q)})
			&& cmd_q >= -$signed({1'b0, $past(limit_q)})))
		else $error("command outside limit after control step");

	// The divider only finishes while the sequencer waits for it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DW)
		else $error("divider finished outside the duty wait");

	// A result appears only when the sequencer hands one over
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised without a finished item");

endmodule
`default_nettype wire
